// ----- src/lmsw_pkg.sv -----
package lmsw_pkg;

  // Geometry of the shadowed digit registers
  localparam int unsigned ROWS       = 8;
  localparam int unsigned DIGIT_BASE = 1;
  localparam int unsigned ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned COL_W      = 3;

  localparam logic [7:0] DIGIT_LO = 8'(DIGIT_BASE);
  localparam logic [7:0] DIGIT_HI = 8'(DIGIT_BASE + ROWS);

  // Command kinds
  localparam logic [2:0] KIND_SET_LED    = 3'd0;
  localparam logic [2:0] KIND_SET_ROW    = 3'd1;
  localparam logic [2:0] KIND_SET_COL    = 3'd2;
  localparam logic [2:0] KIND_WRITE_CHAR = 3'd3;
  localparam logic [2:0] KIND_RAW_WRITE  = 3'd4;
  localparam logic [2:0] KIND_CLEAR      = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] row_index;
    logic [7:0] column_index;
    logic       led_on;
    logic [7:0] pattern;
    logic       dot_on;
    logic [7:0] raw_address;
  } in_item_t;

  typedef struct packed {
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic             load;
    logic             step;
    logic             flush;
    logic [ROW_W-1:0] idx;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;
    logic hold_valid;
    logic out_free;
    logic multi;
  } dp_sts_t;

  // Seven-segment font; unknown codes are blank
  function automatic logic [7:0] font_lookup(input logic [7:0] code);
    logic [7:0] seg;
    seg = 8'h00;
    case (code)
      8'h30: seg = 8'h7E;  8'h31: seg = 8'h30;  8'h32: seg = 8'h6D;
      8'h33: seg = 8'h79;  8'h34: seg = 8'h33;  8'h35: seg = 8'h5B;
      8'h36: seg = 8'h5F;  8'h37: seg = 8'h70;  8'h38: seg = 8'h7F;
      8'h39: seg = 8'h7B;
      8'h61, 8'h41: seg = 8'h77;
      8'h62, 8'h42: seg = 8'h1F;
      8'h63: seg = 8'h0D;  8'h43: seg = 8'h4E;
      8'h64, 8'h44: seg = 8'h3D;
      8'h65, 8'h45: seg = 8'h4F;
      8'h66, 8'h46: seg = 8'h47;
      8'h67, 8'h47: seg = 8'h5E;
      8'h68, 8'h48: seg = 8'h17;
      8'h69: seg = 8'h04;  8'h49: seg = 8'h06;
      8'h6A: seg = 8'h18;  8'h4A: seg = 8'h38;
      8'h6B, 8'h4B: seg = 8'h07;
      8'h6C, 8'h4C: seg = 8'h0E;
      8'h6D, 8'h4D: seg = 8'h76;
      8'h6E, 8'h4E: seg = 8'h15;
      8'h6F: seg = 8'h1D;  8'h4F: seg = 8'h7E;
      8'h70, 8'h50: seg = 8'h67;
      8'h71, 8'h51: seg = 8'h73;
      8'h72: seg = 8'h05;  8'h52: seg = 8'h86;
      8'h73, 8'h53: seg = 8'h5B;
      8'h74, 8'h54: seg = 8'h0F;
      8'h75, 8'h55: seg = 8'h3E;
      8'h76, 8'h56: seg = 8'h1C;
      8'h77, 8'h57: seg = 8'h2A;
      8'h78, 8'h58: seg = 8'h37;
      8'h79, 8'h59: seg = 8'h3B;
      8'h7A, 8'h5A: seg = 8'h69;
      8'h2D: seg = 8'h01;  8'h5F: seg = 8'h08;
      8'h2E: seg = 8'h80;  8'h2F: seg = 8'h24;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ----- src/lmsw_datapath.sv -----
module lmsw_datapath import lmsw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output out_item_t out_data_o
);

  // Latched command, indices already saturated
  logic [2:0]       kind_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             on_q;
  logic [7:0]       pat_q;
  logic             dot_q;
  logic [7:0]       raw_q;

  logic [7:0]       cache_q [ROWS];

  out_item_t        hold_q, hold_d;
  logic             hold_valid_q, hold_valid_d;
  out_item_t        out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [ROW_W-1:0] slot;
  logic [7:0]       data;
  logic [7:0]       addr;
  logic             in_range;
  logic             active;
  logic             emit;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_data_i.kind;
      row_q  <= (in_data_i.row_index > 8'(ROWS - 1)) ? ROW_W'(ROWS - 1)
                                                      : in_data_i.row_index[ROW_W-1:0];
      col_q  <= (|in_data_i.column_index[7:COL_W]) ? {COL_W{1'b1}}
                                                    : in_data_i.column_index[COL_W-1:0];
      on_q   <= in_data_i.led_on;
      pat_q  <= in_data_i.pattern;
      dot_q  <= in_data_i.dot_on;
      raw_q  <= in_data_i.raw_address;
    end
  end

  // Candidate frame for the current step
  always_comb begin
    slot     = row_q;
    data     = pat_q;
    in_range = 1'b1;
    active   = 1'b1;
    case (kind_q)
      KIND_SET_LED: begin
        data        = cache_q[row_q];
        data[col_q] = on_q;
      end
      KIND_SET_ROW: begin
        data = pat_q;
      end
      KIND_SET_COL: begin
        slot        = cmd_i.idx;
        data        = cache_q[cmd_i.idx];
        data[col_q] = pat_q[cmd_i.idx];
      end
      KIND_WRITE_CHAR: begin
        data = font_lookup(pat_q) | {dot_q, 7'b0};
      end
      KIND_RAW_WRITE: begin
        in_range = (raw_q >= DIGIT_LO) && (raw_q < DIGIT_HI);
        slot     = ROW_W'(raw_q - DIGIT_LO);
      end
      KIND_CLEAR: begin
        slot = cmd_i.idx;
        data = 8'h00;
      end
      default: begin
        active = 1'b0;
      end
    endcase
    addr = (kind_q == KIND_RAW_WRITE) ? raw_q : DIGIT_LO + 8'(slot);
    emit = active && (!in_range || (cache_q[slot] != data));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROWS; i++) begin
        cache_q[i] <= 8'hFF;
      end
    end else if (cmd_i.step && emit && in_range) begin
      cache_q[slot] <= data;
    end
  end

  // Hold the newest frame until the next one (or the end) tells whether it is last
  always_comb begin
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    if (cmd_i.step && emit) begin
      if (hold_valid_q) begin
        out_d       = hold_q;
        out_d.last  = 1'b0;
        out_valid_d = 1'b1;
      end
      hold_d.reg_addr = addr;
      hold_d.reg_data = data;
      hold_d.last     = 1'b0;
      hold_valid_d    = 1'b1;
    end
    if (cmd_i.flush) begin
      out_d        = hold_q;
      out_d.last   = 1'b1;
      out_valid_d  = 1'b1;
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign sts_o.emit       = emit;
  assign sts_o.hold_valid = hold_valid_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.multi      = (kind_q == KIND_SET_COL) || (kind_q == KIND_CLEAR);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/lmsw_controller.sv -----
module lmsw_controller import lmsw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [ROW_W-1:0] LAST_IDX = ROW_W'(ROWS - 1);

  logic [1:0]       state_q, state_d;
  logic [ROW_W-1:0] idx_q, idx_d;
  logic             can_step;

  // A kept frame must leave before a new one replaces it
  assign can_step = !sts_i.emit || !sts_i.hold_valid || sts_i.out_free;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_o.load  = 1'b0;
    cmd_o.step  = 1'b0;
    cmd_o.flush = 1'b0;
    cmd_o.idx   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (can_step) begin
          cmd_o.step = 1'b1;
          if (!sts_i.multi || idx_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!sts_i.hold_valid) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- src/led_matrix_shadow_writer.sv -----
// Command front end for an 8x8 LED matrix / 8-digit display driver. Each accepted
// command beat (set LED, set row, set column, write character, raw write, clear)
// becomes zero to eight register-frame beats of (reg_addr, reg_data, last) on the
// output. A shadow copy of the digit registers (reset to 0xFF) drops any digit write
// whose data the register already holds, so a command may give no frame at all;
// last marks the final frame of a command. Row and column indices saturate to 7.
// Timing: one row of the shadow is visited per cycle unless a backed-up output pauses
// the walk; a command walks one row, or every row for set column and clear. in_stall_o
// stays high for all the time a command occupies the block but the accepting cycle.
// A stalled output holds at most one frame in the output register plus one kept
// back to learn whether it is the last; a backed-up output simply pauses the row
// walk and the final flush.
module led_matrix_shadow_writer import lmsw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequence the row walk and the final flush
  lmsw_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  // Shadow registers, frame building and output staging
  lmsw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- src/lmsw_checker.sv -----
module lmsw_checker import lmsw_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic      out_acc;
  logic      prev_valid_q;
  out_item_t prev_q;
  logic [2:0] cnt_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // Track the previous output beat and beats since the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_q       <= '0;
      cnt_q        <= '0;
    end else if (out_acc) begin
      prev_valid_q <= 1'b1;
      prev_q       <= out_data_o;
      cnt_q        <= out_data_o.last ? 3'd0 : cnt_q + 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  a_no_repeat_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && prev_valid_q && out_data_o.reg_addr == prev_q.reg_addr &&
    out_data_o.reg_addr >= DIGIT_LO && out_data_o.reg_addr < DIGIT_HI
    |-> out_data_o.reg_data != prev_q.reg_data)
    else $error("redundant digit write not suppressed");

  a_max_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && cnt_q == 3'd7 |-> out_data_o.last)
    else $error("more than eight frames for one command");

endmodule

bind led_matrix_shadow_writer lmsw_checker u_lmsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
